@@ src/tpag_pkg.sv @@
// Package for the tensor permute address generator.
// Holds widths, register index codes, the controller state type and the
// command and status structs shared by the controller, datapath and top. No dependencies.
`default_nettype none

package tpag_pkg;

    localparam int MAX_DIMS      = 6;
    localparam int DIM_BITS      = 16;
    localparam int OFFSET_BITS   = 32;
    localparam int AXIS_BITS     = 3;
    localparam int IDX_BITS      = 3;
    localparam int PERM_BITS     = AXIS_BITS * MAX_DIMS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = PERM_BITS;
    localparam int PROD_BITS     = OFFSET_BITS + 1;
    localparam int MUL_BITS      = PROD_BITS + DIM_BITS;
    localparam int S_TDATA_BITS  = 8;
    localparam int M_TDATA_BITS  = 2 * OFFSET_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERM_CODE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_BASE = 3'd2;

    localparam logic [2:0]           DIM_COUNT_RESET = 3'd2;
    localparam logic [PERM_BITS-1:0] PERM_CODE_RESET = 18'd8;

    typedef struct packed {
        logic [2:0]                         dim_count;
        logic [PERM_BITS-1:0]               perm_code;
        logic [MAX_DIMS-1:0][DIM_BITS-1:0]  size;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STRIDE_MUL,
        ST_STRIDE_ACC,
        ST_STEP_MUL,
        ST_STEP_ACC
    } t_state;

    typedef struct packed {
        logic                latch;
        logic                stride_mul;
        logic                stride_acc;
        logic                step_mul;
        logic                step_acc;
        logic                advance;
        logic [IDX_BITS-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [IDX_BITS-1:0] first_idx;
    } t_status;

endpackage

`default_nettype wire

@@ src/tpag_cfg.sv @@
// Configuration register file of the tensor permute address generator.
// Depends on tpag_pkg for the register index codes and the t_cfg struct.
`default_nettype none

module tpag_cfg
    import tpag_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                          o_cfg
);

    logic [2:0]                        r_dim_count;
    logic [PERM_BITS-1:0]              r_perm_code;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] r_size;
    logic [IDX_BITS-1:0]               size_sel;

    assign size_sel = IDX_BITS'(i_cfg_index - CFG_SIZE_BASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= DIM_COUNT_RESET;
            r_perm_code <= PERM_CODE_RESET;
            for (int i = 0; i < MAX_DIMS; i++) begin
                r_size[i] <= DIM_BITS'(1);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIM_COUNT: r_dim_count <= i_cfg_data[2:0];
                CFG_PERM_CODE: r_perm_code <= i_cfg_data[PERM_BITS-1:0];
                default:       r_size[size_sel] <= i_cfg_data[DIM_BITS-1:0];
            endcase
        end
    end

    assign o_cfg.dim_count = r_dim_count;
    assign o_cfg.perm_code = r_perm_code;
    assign o_cfg.size      = r_size;

endmodule

`default_nettype wire

@@ src/tpag_ctrl.sv @@
// Controller of the tensor permute address generator: handshake, setup
// sequencing and output valid. Depends on tpag_pkg (t_state, t_cmd, t_status).
`default_nettype none

module tpag_ctrl
    import tpag_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    input  wire logic    i_restart,
    input  wire logic    i_m_tready,
    input  wire t_status i_status,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    output t_cmd         o_cmd
);

    t_state              r_state, n_state;
    logic [IDX_BITS-1:0] r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    logic                s_ready;
    logic                accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign s_ready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign accept  = i_s_tvalid && s_ready;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_restart) begin
                        o_cmd.latch = 1'b1;
                        n_idx       = i_status.first_idx;
                        n_state     = ST_STRIDE_MUL;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_out_valid   = 1'b1;
                    end
                end
            end
            ST_STRIDE_MUL: begin
                o_cmd.stride_mul = 1'b1;
                n_state          = ST_STRIDE_ACC;
            end
            ST_STRIDE_ACC: begin
                o_cmd.stride_acc = 1'b1;
                if (r_idx == '0) begin
                    n_idx   = i_status.first_idx;
                    n_state = ST_STEP_MUL;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = ST_STRIDE_MUL;
                end
            end
            ST_STEP_MUL: begin
                o_cmd.step_mul = 1'b1;
                n_state        = ST_STEP_ACC;
            end
            ST_STEP_ACC: begin
                o_cmd.step_acc = 1'b1;
                if (r_idx == '0) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = ST_STEP_MUL;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

@@ src/tpag_dp.sv @@
// Datapath of the tensor permute address generator: setup validation, stride
// and step tables built through one shared multiplier, and the odometer.
// Depends on tpag_pkg; driven by tpag_ctrl through t_cmd.
`default_nettype none

module tpag_dp
    import tpag_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire t_cmd                   i_cmd,
    output t_status                     o_status,
    output logic [OFFSET_BITS-1:0]      o_source_offset,
    output logic [OFFSET_BITS-1:0]      o_output_index,
    output logic                        o_last,
    output logic                        o_config_error
);

    // Pass setup latched at restart.
    logic [IDX_BITS-1:0]                    r_dims;
    logic [MAX_DIMS-1:0][AXIS_BITS-1:0]     r_axis;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]      r_size;
    logic                                   r_err;
    logic                                   r_ovf;
    // Tables and accumulators for the setup sequence.
    logic [MAX_DIMS-1:0][OFFSET_BITS-1:0]   r_stride;
    logic [MAX_DIMS-1:0][OFFSET_BITS-1:0]   r_step;
    logic [OFFSET_BITS-1:0]                 r_acc;
    logic [PROD_BITS-1:0]                   r_prod;
    logic [MUL_BITS-1:0]                    r_mul;
    // Odometer.
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]      r_cnt;
    logic [OFFSET_BITS-1:0]                 r_offset;
    logic [OFFSET_BITS-1:0]                 r_index;

    logic                                   dims_ok;
    logic [IDX_BITS-1:0]                    lat_n;
    logic [MAX_DIMS-1:0][AXIS_BITS-1:0]     lat_axis;
    logic                                   lat_err;

    logic [DIM_BITS-1:0]                    eff_size;
    logic [OFFSET_BITS-1:0]                 sel_stride;
    logic [PROD_BITS-1:0]                   mul_a;
    logic [DIM_BITS-1:0]                    mul_b;
    logic [MUL_BITS-1:0]                    mul_p;
    logic                                   prod_big;

    logic                                   found;
    logic [IDX_BITS-1:0]                    k;
    logic                                   err;

    // Validation of the configuration, evaluated at restart.
    always_comb begin
        dims_ok  = (i_cfg.dim_count >= 3'd2) && (i_cfg.dim_count <= 3'(MAX_DIMS));
        lat_n    = dims_ok ? IDX_BITS'(i_cfg.dim_count) : IDX_BITS'(2);
        lat_err  = !dims_ok;
        lat_axis = '0;
        for (int i = 0; i < MAX_DIMS; i++) begin
            if (IDX_BITS'(i) < lat_n) begin
                if (IDX_BITS'(i_cfg.perm_code[AXIS_BITS*i +: AXIS_BITS]) >= lat_n) begin
                    lat_err = 1'b1;
                end else begin
                    lat_axis[i] = i_cfg.perm_code[AXIS_BITS*i +: AXIS_BITS];
                end
                for (int j = 0; j < i; j++) begin
                    if (i_cfg.perm_code[AXIS_BITS*i +: AXIS_BITS]
                            == i_cfg.perm_code[AXIS_BITS*j +: AXIS_BITS]) begin
                        lat_err = 1'b1;
                    end
                end
                if (i_cfg.size[i] == '0) begin
                    lat_err = 1'b1;
                end
            end
        end
    end

    assign o_status.first_idx = lat_n - 1'b1;

    // A zero size counts as one; it has already raised the error flag.
    assign eff_size   = (i_cfg.size[i_cmd.idx] == '0) ? DIM_BITS'(1) : i_cfg.size[i_cmd.idx];
    assign sel_stride = r_stride[r_axis[i_cmd.idx]];

    always_comb begin
        if (i_cmd.step_mul) begin
            mul_a = {1'b0, sel_stride};
            mul_b = r_size[i_cmd.idx] - 1'b1;
        end else begin
            mul_a = r_prod;
            mul_b = eff_size;
        end
    end

    assign mul_p = MUL_BITS'(mul_a) * MUL_BITS'(mul_b);

    // Element count beyond 2^OFFSET_BITS.
    assign prod_big = (|r_mul[MUL_BITS-1:PROD_BITS])
                   || (r_mul[PROD_BITS-1] && (|r_mul[OFFSET_BITS-1:0]));

    // Innermost output dimension whose counter is not at its end.
    always_comb begin
        found = 1'b0;
        k     = '0;
        for (int j = 0; j < MAX_DIMS; j++) begin
            if ((IDX_BITS'(j) < r_dims) && (r_cnt[j] != r_size[j] - 1'b1)) begin
                found = 1'b1;
                k     = IDX_BITS'(j);
            end
        end
    end

    assign err = r_err || r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims   <= IDX_BITS'(2);
            r_err    <= 1'b0;
            r_ovf    <= 1'b0;
            r_offset <= '0;
            r_index  <= '0;
            for (int i = 0; i < MAX_DIMS; i++) begin
                r_axis[i] <= AXIS_BITS'(i);
                r_size[i] <= DIM_BITS'(1);
                r_cnt[i]  <= '0;
            end
        end else begin
            if (i_cmd.latch) begin
                r_dims   <= lat_n;
                r_axis   <= lat_axis;
                r_err    <= lat_err;
                r_ovf    <= 1'b0;
                r_offset <= '0;
                r_index  <= '0;
                r_prod   <= PROD_BITS'(1);
                r_acc    <= '0;
                for (int i = 0; i < MAX_DIMS; i++) begin
                    r_size[i]   <= DIM_BITS'(1);
                    r_cnt[i]    <= '0;
                    r_stride[i] <= '0;
                end
            end
            if (i_cmd.stride_mul || i_cmd.step_mul) begin
                r_mul <= mul_p;
            end
            if (i_cmd.stride_acc) begin
                r_stride[i_cmd.idx] <= r_prod[OFFSET_BITS-1:0];
                r_prod              <= r_mul[PROD_BITS-1:0];
                if (prod_big) begin
                    r_ovf <= 1'b1;
                end
                // Output dimensions that read this input axis take its size.
                for (int j = 0; j < MAX_DIMS; j++) begin
                    if ((IDX_BITS'(j) < r_dims) && (IDX_BITS'(r_axis[j]) == i_cmd.idx)) begin
                        r_size[j] <= eff_size;
                    end
                end
            end
            if (i_cmd.step_mul) begin
                // Step taken when this dimension counts up and all inner ones wrap.
                r_step[i_cmd.idx] <= sel_stride - r_acc;
            end
            if (i_cmd.step_acc) begin
                r_acc <= r_acc + r_mul[OFFSET_BITS-1:0];
            end
            if (i_cmd.advance && !err) begin
                if (found) begin
                    r_offset <= r_offset + r_step[k];
                    r_index  <= r_index + 1'b1;
                    for (int j = 0; j < MAX_DIMS; j++) begin
                        if (IDX_BITS'(j) == k) begin
                            r_cnt[j] <= r_cnt[j] + 1'b1;
                        end else if (IDX_BITS'(j) > k) begin
                            r_cnt[j] <= '0;
                        end
                    end
                end else begin
                    r_offset <= '0;
                    r_index  <= '0;
                    for (int j = 0; j < MAX_DIMS; j++) begin
                        r_cnt[j] <= '0;
                    end
                end
            end
        end
    end

    assign o_source_offset = err ? '0 : r_offset;
    assign o_output_index  = err ? '0 : r_index;
    assign o_last          = err || !found;
    assign o_config_error  = err;

endmodule

`default_nettype wire

@@ src/tensor_permute_address_gen_top.sv @@
// Top level of the tensor permute address generator.
// Depends on tpag_pkg, tpag_cfg, tpag_ctrl and tpag_dp.
//
//   Port group   Dir  Beat contents
//   s_axis       in   tdata[0] restart, tdata[7:1] zero
//   m_axis       out  tdata[31:0] source_offset, tdata[63:32] output_index,
//                     tlast last, tuser[0] config_error
//   cfg          in   we, index 0..7, data[17:0]
//
// A beat without restart gives its result in the next cycle, so passes stream
// at one address per cycle while the output is not stalled; the odometer step
// is one table read and one add. A restart beat builds the stride table, then
// the step table, one dimension at a time through a single shared multiplier.
// Input is taken only in the idle state while the output register is empty or
// drains that cycle. Reset is synchronous; there is no clearing pass.
`default_nettype none

module tensor_permute_address_gen_top
    import tpag_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    input  wire logic [S_TDATA_BITS-1:0]  i_s_tdata,   // [0] restart
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    output logic [M_TDATA_BITS-1:0]       o_m_tdata,   // [31:0] source_offset, [63:32] output_index
    output logic                          o_m_tlast,
    output logic                          o_m_tuser,   // [0] config_error
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg                   cfg;
    t_cmd                   cmd;
    t_status                status;
    logic [OFFSET_BITS-1:0] source_offset;
    logic [OFFSET_BITS-1:0] output_index;

    tpag_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tpag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_restart  (i_s_tdata[0]),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    tpag_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_source_offset (source_offset),
        .o_output_index  (output_index),
        .o_last          (o_m_tlast),
        .o_config_error  (o_m_tuser)
    );

    assign o_m_tdata = {output_index, source_offset};

endmodule

`default_nettype wire

@@ src/tpag_checker.sv @@
// Port-level checker for the tensor permute address generator, bound to the
// top level. Depends on tpag_pkg for the port widths.
`default_nettype none

module tpag_checker
    import tpag_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_s_tvalid,
    input wire logic                    o_s_tready,
    input wire logic [S_TDATA_BITS-1:0] i_s_tdata,
    input wire logic                    o_m_tvalid,
    input wire logic                    i_m_tready,
    input wire logic [M_TDATA_BITS-1:0] o_m_tdata,
    input wire logic                    o_m_tlast,
    input wire logic                    o_m_tuser
);

    // A result is shown empty after reset.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled result blocks the input side.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while result stalled");

    // An advance beat yields its result on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tdata[0]) |=> o_m_tvalid)
        else $error("advance result missing");

    // A bad setup reports offset 0, index 0 and last.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0) && o_m_tlast)
        else $error("config error result not cleared");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind tensor_permute_address_gen_top tpag_checker u_tpag_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
